[hw/rtl/trpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package trpd_pkg;

    localparam int INDEX_BITS = 24;
    localparam int DATA_W     = 8;
    localparam int PIX_W      = 32;
    localparam int COUNT_W    = 8;
    localparam int START_W    = 24;
    localparam int BPP_W      = 3;
    localparam int PCOUNT_W   = 24;
    localparam int POS_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT     = 1'b1;

    localparam logic [BPP_W-1:0]    BPP_RESET    = 3'd3;
    localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 24'd1;
    localparam logic [BPP_W-1:0]    BPP_MIN      = 3'd1;
    localparam logic [BPP_W-1:0]    BPP_MAX      = 3'd4;

    localparam logic [DATA_W-1:0] RAW_LIMIT = 8'd128;
    localparam logic [DATA_W-1:0] RUN_BIAS  = 8'd127;

    typedef struct packed {
        logic [BPP_W-1:0]    bytes_per_pixel;
        logic [PCOUNT_W-1:0] pixel_count;
    } t_cfg;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              new_image;
    } t_item;

    typedef struct packed {
        logic [PIX_W-1:0]   pixel_value;
        logic [COUNT_W-1:0] repeat_count;
        logic [START_W-1:0] start_index;
        logic               image_done;
        logic               overflow_error;
    } t_result;

endpackage
`default_nettype wire

[hw/rtl/trpd_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
module trpd_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [trpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [trpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output      trpd_pkg::t_cfg                 o_cfg
);
    import trpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_pixel <= BPP_RESET;
            r_cfg.pixel_count     <= PCOUNT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= i_cfg_data[BPP_W-1:0];
                REG_PIXEL_COUNT:     r_cfg.pixel_count     <= i_cfg_data[PCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[hw/rtl/trpd_decode.sv]
`timescale 1ns / 1ps
`default_nettype none
module trpd_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input       trpd_pkg::t_item i_item,
    input       trpd_pkg::t_cfg  i_cfg,
    output      logic            o_result_valid,
    output      trpd_pkg::t_result o_result
);
    import trpd_pkg::*;

    logic                  r_expect, n_expect;
    logic                  r_raw, n_raw;
    logic [COUNT_W-1:0]    r_left, n_left;
    logic [PIX_W-1:0]      r_pixel_bytes, n_pixel_bytes;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [INDEX_BITS-1:0] r_pixels_done, n_pixels_done;
    logic                  r_stopped, n_stopped;

    always_comb begin
        logic [BPP_W-1:0]      bpp;
        logic [BPP_W-1:0]      pos_next;
        logic [PIX_W-1:0]      bytes;
        logic [INDEX_BITS-1:0] pc;
        logic [INDEX_BITS-1:0] remaining;
        logic [COUNT_W-1:0]    left;
        logic [COUNT_W-1:0]    count;

        bpp       = i_cfg.bytes_per_pixel;
        pos_next  = '0;
        bytes     = '0;
        pc        = '0;
        remaining = '0;
        left      = '0;
        count     = '0;

        // a new-image byte clears decoding before it is taken as a header
        if (i_item.new_image) begin
            n_expect      = 1'b1;
            n_raw         = 1'b0;
            n_left        = '0;
            n_pixel_bytes = '0;
            n_pos         = '0;
            n_pixels_done = '0;
            n_stopped     = 1'b0;
        end else begin
            n_expect      = r_expect;
            n_raw         = r_raw;
            n_left        = r_left;
            n_pixel_bytes = r_pixel_bytes;
            n_pos         = r_pos;
            n_pixels_done = r_pixels_done;
            n_stopped     = r_stopped;
        end

        o_result_valid = 1'b0;
        o_result       = '0;

        if (!n_stopped) begin
            if (n_expect) begin
                if (i_item.data_byte < RAW_LIMIT) begin
                    n_raw  = 1'b1;
                    n_left = i_item.data_byte + 8'd1;
                end else begin
                    n_raw  = 1'b0;
                    n_left = i_item.data_byte - RUN_BIAS;
                end
                n_expect      = 1'b0;
                n_pixel_bytes = '0;
                n_pos         = '0;
            end else begin
                if (bpp < BPP_MIN) bpp = BPP_MIN;
                if (bpp > BPP_MAX) bpp = BPP_MAX;
                bytes    = n_pixel_bytes
                         | (PIX_W'(i_item.data_byte) << {n_pos, 3'b000});
                pos_next = {1'b0, n_pos} + 3'd1;
                if (pos_next < bpp) begin
                    n_pixel_bytes = bytes;
                    n_pos         = pos_next[POS_W-1:0];
                end else begin
                    pc = INDEX_BITS'(i_cfg.pixel_count);
                    if (pc == '0) pc = INDEX_BITS'(1);
                    if (n_pixels_done >= pc) begin
                        n_stopped = 1'b1;
                    end else begin
                        remaining = pc - n_pixels_done;
                        left      = (n_left == '0) ? 8'd1 : n_left;
                        count     = n_raw ? 8'd1 : left;
                        // clip a run to the pixels still owed to the image
                        if (INDEX_BITS'(count) > remaining) count = remaining[COUNT_W-1:0];

                        o_result_valid              = 1'b1;
                        o_result.pixel_value        = bytes;
                        o_result.repeat_count       = count;
                        o_result.start_index        = START_W'(n_pixels_done);
                        o_result.image_done         = INDEX_BITS'(count) >= remaining;
                        o_result.overflow_error     = INDEX_BITS'(left) > remaining;

                        n_pixels_done = n_pixels_done + INDEX_BITS'(count);
                        n_left        = left - count;
                        if (n_left == '0) n_expect = 1'b1;
                        n_pixel_bytes = '0;
                        n_pos         = '0;
                        if (o_result.image_done) n_stopped = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect      <= 1'b1;
            r_raw         <= 1'b0;
            r_left        <= '0;
            r_pixel_bytes <= '0;
            r_pos         <= '0;
            r_pixels_done <= '0;
            r_stopped     <= 1'b0;
        end else if (i_step) begin
            r_expect      <= n_expect;
            r_raw         <= n_raw;
            r_left        <= n_left;
            r_pixel_bytes <= n_pixel_bytes;
            r_pos         <= n_pos;
            r_pixels_done <= n_pixels_done;
            r_stopped     <= n_stopped;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/tga_rle_pixel_decoder_top.sv]
// Run-length pixel decoder: takes one data byte per cycle and gives at most one result per
// byte (a literal pixel, or a whole run clipped to the image). A taken byte is held in
// the input register, then passes through the decode logic into the result register.
// The rate is one byte every cycle, set by the single decode pass that updates packet,
// pixel and index state per byte; it drops only while a waiting result is stalled. A
// byte with new_image high restarts decoding; after the result that completes the image
// bytes are dropped until the next new_image byte. The configuration port is always
// ready; write it only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none
module tga_rle_pixel_decoder_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output      logic                            o_stall,
    input  wire logic [trpd_pkg::DATA_W-1:0]     i_data_byte,
    input  wire logic                            i_new_image,
    output      logic                            o_valid,
    input  wire logic                            i_stall,
    output      logic [trpd_pkg::PIX_W-1:0]      o_pixel_value,
    output      logic [trpd_pkg::COUNT_W-1:0]    o_repeat_count,
    output      logic [trpd_pkg::START_W-1:0]    o_start_index,
    output      logic                            o_image_done,
    output      logic                            o_overflow_error,
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [trpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [trpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import trpd_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result res;
    logic    res_valid;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    trpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // decode the held byte once the result register is free or being drained
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    trpd_decode u_decode (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_item         (r_in),
        .i_cfg          (cfg),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in.data_byte <= i_data_byte;
            r_in.new_image <= i_new_image;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_pixel_value    = r_out.pixel_value;
    assign o_repeat_count   = r_out.repeat_count;
    assign o_start_index    = r_out.start_index;
    assign o_image_done     = r_out.image_done;
    assign o_overflow_error = r_out.overflow_error;

endmodule
`default_nettype wire

[hw/rtl/trpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module trpd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_valid,
    input wire logic                            i_stall,
    input wire logic [trpd_pkg::PIX_W-1:0]      o_pixel_value,
    input wire logic [trpd_pkg::COUNT_W-1:0]    o_repeat_count,
    input wire logic [trpd_pkg::START_W-1:0]    o_start_index,
    input wire logic                            o_image_done,
    input wire logic                            o_overflow_error
);
    import trpd_pkg::*;

    logic r_after_done;

    // remember whether the last delivered transaction closed an image
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_done <= 1'b0;
        end else if (o_valid && !i_stall) begin
            r_after_done <= o_image_done;
        end
    end

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_repeat_count != '0)
        else $error("result with zero repeat count");

    // a run that overflows is clipped and closes the image; only a literal pixel stays open
    a_overflow_open_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow_error && !o_image_done |-> o_repeat_count == COUNT_W'(1))
        else $error("open overflow result covers more than one pixel");

    a_restart_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_after_done |-> o_start_index == '0)
        else $error("result after a finished image does not start at pixel zero");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pixel_value)
            && $stable(o_repeat_count) && $stable(o_start_index))
        else $error("stalled result changed");

endmodule

bind tga_rle_pixel_decoder_top trpd_checker u_trpd_checker (.*);
`default_nettype wire

[test/tga_rle_pixel_decoder_top_tb.sv]
`timescale 1ns / 1ps
module tga_rle_pixel_decoder_top_tb;
    import trpd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 760;
    localparam int MAX_IMAGE    = 60;

    typedef enum {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [DATA_W-1:0]     i_data_byte = '0;
    logic                  i_new_image = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [PIX_W-1:0]      o_pixel_value;
    logic [COUNT_W-1:0]    o_repeat_count;
    logic [START_W-1:0]    o_start_index;
    logic                  o_image_done;
    logic                  o_overflow_error;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Register mirror and decoder state of the predictor
    logic [BPP_W-1:0]    cfg_bpp = BPP_RESET;
    logic [PCOUNT_W-1:0] cfg_pcount = PCOUNT_RESET;
    logic                dec_expect_header;
    logic                dec_raw;
    logic [7:0]          dec_left;
    logic [PIX_W-1:0]    dec_pixel;
    logic [POS_W-1:0]    dec_pos;
    logic [INDEX_BITS-1:0] dec_done_px;
    logic                dec_stopped;

    t_result expected_runs[$];
    t_result exp_run;
    int      fail_count = 0;
    int      cycle_count = 0;
    int      useful_bytes = 0;
    int      burst_left = 0;
    bit      sender_gaps = 1'b1;
    int      rx_hold_req = 0;
    int      rx_hold_cnt = 0;
    int      rx_mode_left = 0;
    int      rx_phase = 0;
    t_rx_mode rx_mode = RX_FREE;

    tga_rle_pixel_decoder_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_new_image      (i_new_image),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_pixel_value    (o_pixel_value),
        .o_repeat_count   (o_repeat_count),
        .o_start_index    (o_start_index),
        .o_image_done     (o_image_done),
        .o_overflow_error (o_overflow_error),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic int pixel_width(input logic [BPP_W-1:0] bpp);
        if (bpp == 0) return 1;
        if (bpp > 4) return 4;
        return int'(bpp);
    endfunction

    function automatic void clear_decode();
        dec_expect_header = 1'b1;
        dec_raw = 1'b0;
        dec_left = '0;
        dec_pixel = '0;
        dec_pos = '0;
        dec_done_px = '0;
        dec_stopped = 1'b0;
    endfunction

    // Advance the decoder by one byte; returns 1 when the byte is dropped
    function automatic bit decode_byte(input logic [7:0] data, input logic new_img,
                                       output bit got, output t_result res);
        int                    bpp;
        logic [PCOUNT_W-1:0]   pc;
        logic [PCOUNT_W-1:0]   remaining;
        logic [8:0]            left;
        logic [8:0]            count;
        logic [POS_W-1:0]      pos;
        bit                    over;
        bit                    done;
        got = 1'b0;
        res = '0;
        if (new_img) clear_decode();
        if (dec_stopped) return 1'b1;
        if (dec_expect_header) begin
            dec_raw = data < RAW_LIMIT;
            dec_left = dec_raw ? data + 8'd1 : data - RUN_BIAS;
            dec_expect_header = 1'b0;
            dec_pixel = '0;
            dec_pos = '0;
            return 1'b0;
        end
        bpp = pixel_width(cfg_bpp);
        pos = dec_pos;
        dec_pixel = dec_pixel | (PIX_W'(data) << (8 * pos));
        if (int'(pos) + 1 < bpp) begin
            dec_pos = pos + 2'd1;
            return 1'b0;
        end
        pc = (cfg_pcount == 0) ? PCOUNT_W'(1) : cfg_pcount;
        if (dec_done_px >= pc) begin
            dec_stopped = 1'b1;
            return 1'b0;
        end
        remaining = pc - dec_done_px;
        left = (dec_left == 0) ? 9'd1 : {1'b0, dec_left};
        count = dec_raw ? 9'd1 : left;
        over = PCOUNT_W'(left) > remaining;
        if (PCOUNT_W'(count) > remaining) count = remaining[8:0];
        done = PCOUNT_W'(count) >= remaining;
        res.pixel_value = dec_pixel;
        res.repeat_count = count[7:0];
        res.start_index = dec_done_px;
        res.image_done = done;
        res.overflow_error = over;
        got = 1'b1;
        dec_done_px = dec_done_px + INDEX_BITS'(count);
        dec_left = 8'(left - count);
        if (dec_left == 0) dec_expect_header = 1'b1;
        dec_pixel = '0;
        dec_pos = '0;
        if (done) dec_stopped = 1'b1;
        return 1'b0;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic new_img);
        int      gap;
        bit      got;
        bit      dropped;
        t_result res;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_data_byte <= data;
        i_new_image <= new_img;
        do @(posedge i_clk); while (o_stall);
        dropped = decode_byte(data, new_img, got, res);
        if (got) expected_runs.push_back(res);
        if (!dropped) useful_bytes++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_BYTES_PER_PIXEL) cfg_bpp = value[BPP_W-1:0];
        else cfg_pcount = value[PCOUNT_W-1:0];
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold the sender until every result is in and no byte is left in flight
    task automatic wait_idle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_runs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic test_reset_values();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h12, 1'b0);
    endtask

    task automatic test_packet_kinds();
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 24'd1);
        write_reg(REG_PIXEL_COUNT, 24'd200);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
    endtask

    task automatic test_clipped_overflow();
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 24'd7);
        write_reg(REG_PIXEL_COUNT, 24'd0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h33, 1'b0);
    endtask

    task automatic test_mid_image_config();
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 24'd2);
        write_reg(REG_PIXEL_COUNT, 24'd3);
        send_byte(8'h02, 1'b1);
        send_byte(8'h11, 1'b0);
        // shrink the pixel width while a pixel is half assembled
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 24'd0);
        send_byte(8'h22, 1'b0);
        // lower the pixel count below the pixels already decoded
        wait_idle();
        write_reg(REG_PIXEL_COUNT, 24'd1);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_BYTES_PER_PIXEL, 24'd1);
        write_reg(REG_PIXEL_COUNT, 24'hFFFFFF);
        sender_gaps = 1'b0;
        rx_hold_req = 60;
        send_byte(8'h7F, 1'b1);
        repeat (40) send_byte(8'($urandom_range(0, 255)), 1'b0);
        sender_gaps = 1'b1;
        wait_idle();
    endtask

    task automatic send_image();
        int bpp;
        int target;
        int planned;
        int remaining;
        int len;
        int npix;
        int r;
        bit raw;
        bit broken;
        bit first;
        bpp = pixel_width(cfg_bpp);
        target = (cfg_pcount == 0) ? 1 : int'(cfg_pcount);
        if (target > MAX_IMAGE) target = MAX_IMAGE;
        planned = 0;
        first = 1'b1;
        broken = 1'b0;
        while (planned < target && !broken) begin
            // drop the rest of the image now and then, so the next header cuts in
            if (!first && $urandom_range(0, 99) < 4) break;
            remaining = target - planned;
            raw = $urandom_range(0, 1);
            r = $urandom_range(0, 99);
            if (r < 3) len = $urandom_range(1, 128);
            else if (r < 15) len = remaining + $urandom_range(1, 3);
            else len = $urandom_range(1, remaining < 6 ? remaining : 6);
            if (len > 128) len = 128;
            send_byte(raw ? 8'(len - 1) : 8'(len + 127), first);
            first = 1'b0;
            npix = raw ? len : 1;
            for (int p = 0; p < npix && !broken; p++) begin
                for (int k = 0; k < bpp && !broken; k++) begin
                    if ($urandom_range(0, 199) == 0) broken = 1'b1;
                    else send_byte(8'($urandom_range(0, 255)), 1'b0);
                end
            end
            planned += len;
        end
        if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 3))
                send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic test_random_images();
        int start;
        int r;
        logic [CFG_DATA_W-1:0] value;
        start = useful_bytes;
        while (useful_bytes - start < RANDOM_BYTES) begin
            wait_idle();
            sender_gaps = $urandom_range(0, 3) != 0;
            r = $urandom_range(0, 9);
            value = (r < 8) ? CFG_DATA_W'($urandom_range(1, 4))
                            : CFG_DATA_W'($urandom_range(0, 7) & 7);
            if ($urandom_range(0, 3) == 0)
                value[CFG_DATA_W-1:BPP_W] = (CFG_DATA_W - BPP_W)'($urandom);
            write_reg(REG_BYTES_PER_PIXEL, value);
            r = $urandom_range(0, 99);
            if (r < 5) value = '0;
            else if (r < 10) value = 24'hFFFFFF;
            else if (r < 20) value = CFG_DATA_W'($urandom_range(25, 300));
            else value = CFG_DATA_W'($urandom_range(1, 24));
            write_reg(REG_PIXEL_COUNT, value);
            repeat ($urandom_range(1, 3)) send_image();
        end
        sender_gaps = 1'b1;
    endtask

    // Receiver: stall on its own pattern, or hold off for a requested stretch
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_cnt = rx_hold_req;
            rx_hold_req = 0;
        end
        if (rx_hold_cnt > 0) begin
            rx_hold_cnt--;
            i_stall <= 1'b1;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 4));
                rx_mode_left = $urandom_range(8, 80);
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_FREE:  i_stall <= 1'b0;
                RX_LIGHT: i_stall <= $urandom_range(0, 3) == 0;
                RX_HALF:  i_stall <= $urandom_range(0, 1) == 1;
                RX_HEAVY: i_stall <= $urandom_range(0, 4) != 0;
                default:  i_stall <= (rx_phase % 3) == 0;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_runs.size() == 0) begin
                $error("result with nothing expected: pixel_value %0h start_index %0h",
                       o_pixel_value, o_start_index);
                fail_count++;
            end else begin
                exp_run = expected_runs.pop_front();
                check_field("pixel_value", exp_run.pixel_value, o_pixel_value);
                check_field("repeat_count", 32'(exp_run.repeat_count), 32'(o_repeat_count));
                check_field("start_index", 32'(exp_run.start_index), 32'(o_start_index));
                check_field("image_done", 32'(exp_run.image_done), 32'(o_image_done));
                check_field("overflow_error", 32'(exp_run.overflow_error),
                            32'(o_overflow_error));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int drain_wait;
        clear_decode();
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_packet_kinds();
        test_clipped_overflow();
        test_mid_image_config();
        test_backpressure();
        test_random_images();

        @(negedge i_clk);
        i_valid <= 1'b0;
        drain_wait = 0;
        while (expected_runs.size() != 0 && drain_wait < 5000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_runs.size() != 0) begin
            $error("%0d expected results never arrived", expected_runs.size());
            fail_count++;
        end
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
